@@ rtl/shb_pkg.sv @@
package shb_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int SPEED_SHIFT     = 13;
    localparam int CURVE_SHIFT     = ANGLE_FRAC_BITS + 16;
    localparam int BLEND_SHIFT     = 15;

    localparam logic [31:0]        MOTOR_GAIN     = 32'd731;
    localparam logic signed [27:0] MOTOR_OFFS     = 28'sd2203648;
    localparam logic [31:0]        COEF_LEFT      = 32'd50745750;
    localparam logic [31:0]        COEF_RIGHT     = 32'd49591792;
    localparam logic [31:0]        OFFS_LEFT_MAG  = 32'd1214113;
    localparam logic [31:0]        OFFS_RIGHT_MAG = 32'd4720270;
    localparam logic               OFFS_LEFT_NEG  = 1'b1;
    localparam logic               OFFS_RIGHT_NEG = 1'b0;
    localparam logic signed [15:0] GAIN_BASE      = 16'sd300;

    typedef enum logic [2:0] {
        DIR_NEUTRAL,
        DIR_LEFT,
        DIR_RIGHT,
        DIR_L2R,
        DIR_R2L
    } t_dir;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MRUN,
        ST_DRUN,
        ST_F_MOT,
        ST_F_AG,
        ST_F_K,
        ST_F_O,
        ST_F_N,
        ST_F_Q,
        ST_F_W,
        ST_F_B,
        ST_F_FIN,
        ST_PUT
    } t_state;

    typedef enum logic [2:0] {
        CFG_MOTOR_MIN,
        CFG_MOTOR_MAX,
        CFG_STEER_MIN,
        CFG_STEER_MAX,
        CFG_HYST_DELTA,
        CFG_TRANS_STEPS,
        CFG_GAIN_DIV
    } t_cfg_idx;

    function automatic logic signed [7:0] abs8(input logic signed [7:0] x);
        return x[7] ? -x : x;
    endfunction

endpackage

@@ rtl/steering_hysteresis_blend.sv @@
// The block takes one input word at a time and accepts no new word until the result word
// is loaded into the output register; dropped words are consumed in idle with no result.
// Each product and quotient is a bit-serial pass of the shared shift-add multiplier or
// restoring divider; left and right modes need fewer passes than the other modes.
// Reset (synchronous, active low) restores register defaults, neutral direction,
// zero counter, cleared switching and jump flags and a zero reference angle.
module steering_hysteresis_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // target_speed[15:0], steer_angle[31:16], lookahead_angle[47:32],
    // applied_motor_level[57:48], zero[63:58]
    input  logic [63:0] i_s_tdata,
    // jump_seen[0], driving_enabled[1]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // motor_level[9:0], steering_command[20:10], zero[23:21]
    output logic [23:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    shb_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [4:0]  r_cnt, n_cnt;

    logic [9:0]         r_mmin, r_mmax;
    logic signed [10:0] r_cmin, r_cmax;
    logic [11:0]        r_hdelta, r_gdiv;
    logic [3:0]         r_tsteps;

    shb_pkg::t_dir      r_dir, n_dir;
    logic signed [5:0]  r_tc, n_tc;
    logic               r_swl, n_swl, r_swr, n_swr, r_jl, n_jl;
    logic signed [15:0] r_ref, n_ref;

    logic signed [15:0] r_ts, n_ts, r_sa, n_sa;
    logic [9:0]         r_p, n_p;
    logic [31:0]        r_ma, n_ma, r_mb, n_mb;
    logic [63:0]        r_mp, n_mp;
    logic [31:0]        r_dq, n_dq;
    logic [11:0]        r_dd, n_dd, r_rem, n_rem;
    logic               r_sel, n_sel;
    logic [9:0]         r_motor, n_motor;
    logic               r_agneg, n_agneg;
    logic [31:0]        r_ag, n_ag;
    logic signed [56:0] r_kag, n_kag, r_num, n_num;
    logic               r_numneg, n_numneg;
    logic signed [10:0] r_cl, n_cl, r_cr, n_cr, r_b, n_b;
    logic [19:0]        r_wl, n_wl, r_wr, n_wr;
    logic               r_wneg_l, n_wneg_l, r_wneg_r, n_wneg_r;
    logic signed [32:0] r_acc, n_acc;
    logic               r_ovalid, n_ovalid;
    logic [9:0]         r_omot, n_omot;
    logic signed [10:0] r_ostr, n_ostr;

    logic               s_acc, in_drop, in_jump;
    logic signed [15:0] in_ts, in_sa, in_la;
    logic [11:0]        d_eff;
    logic [3:0]         s_eff;
    logic signed [7:0]  u_s, cc8, wl_num, wr_num, wl_mag, wr_mag;

    shb_pkg::t_dir      c_dir;
    logic signed [7:0]  c_c;
    logic               c_swl, c_swr, c_jl;
    logic signed [15:0] c_ref;
    logic signed [17:0] la_x, ref_x, delta_x;

    logic [32:0]        m_sum;
    logic [12:0]        d_t, d_sub;
    logic               d_ge;
    logic signed [27:0] mot_num, mot_q;
    logic signed [15:0] g;
    logic [15:0]        g_mag, sa_mag;
    logic signed [56:0] t2;
    logic [56:0]        num_mag, num_shift;
    logic               offneg, bneg;
    logic signed [32:0] qs, cmin_x, cmax_x, term, bq;
    logic signed [10:0] cval;
    logic [10:0]        cl_mag, cr_mag;

    assign in_ts   = i_s_tdata[15:0];
    assign in_sa   = i_s_tdata[31:16];
    assign in_la   = i_s_tdata[47:32];
    assign in_jump = i_s_tuser[0];
    assign in_drop = !i_s_tuser[1] || (in_ts == 16'sd0 && in_sa == 16'sd0);

    assign o_s_tready  = (r_state == shb_pkg::ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {3'b000, r_ostr, r_omot};

    assign d_eff  = (r_gdiv == 12'd0) ? 12'd1 : r_gdiv;
    assign s_eff  = (r_tsteps == 4'd0) ? 4'd1 : r_tsteps;
    assign u_s    = $signed({4'b0000, s_eff});
    assign cc8    = (r_dir == shb_pkg::DIR_NEUTRAL) ? 8'sd0 : 8'(r_tc);
    assign wl_num = u_s - cc8;
    assign wr_num = u_s + cc8;
    assign wl_mag = shb_pkg::abs8(wl_num);
    assign wr_mag = shb_pkg::abs8(wr_num);
    assign cl_mag = r_cl[10] ? 11'(-r_cl) : 11'(r_cl);
    assign cr_mag = r_cr[10] ? 11'(-r_cr) : 11'(r_cr);

    always_comb begin
        la_x    = $signed({{2{in_la[15]}}, in_la});
        ref_x   = $signed({{2{r_ref[15]}}, r_ref});
        delta_x = $signed({6'b000000, r_hdelta});
        c_c     = $signed({{2{r_tc[5]}}, r_tc});
        c_dir   = r_dir;
        c_swl   = r_swl;
        c_swr   = r_swr;
        c_jl    = r_jl;
        c_ref   = r_ref;
        if (shb_pkg::abs8(c_c) > u_s) begin
            c_c = 8'sd0;
        end
        if (c_swl || c_swr) begin
            if (shb_pkg::abs8(c_c) >= u_s) begin
                c_swl = 1'b0;
                c_swr = 1'b0;
                if (c_dir == shb_pkg::DIR_L2R) begin
                    c_dir = shb_pkg::DIR_RIGHT;
                end else if (c_dir == shb_pkg::DIR_R2L) begin
                    c_dir = shb_pkg::DIR_LEFT;
                end
            end else if (c_dir == shb_pkg::DIR_L2R) begin
                c_c = c_c + 8'sd1;
            end else if (c_dir == shb_pkg::DIR_R2L) begin
                c_c = c_c - 8'sd1;
            end
        end
        if (!in_jump) begin
            c_jl = 1'b0;
            if (la_x < ref_x - delta_x) begin
                if (c_dir != shb_pkg::DIR_LEFT && c_dir != shb_pkg::DIR_R2L) begin
                    if (c_dir == shb_pkg::DIR_NEUTRAL) begin
                        c_dir = shb_pkg::DIR_LEFT;
                        c_c   = -u_s;
                    end else if (!c_swl) begin
                        c_dir = shb_pkg::DIR_R2L;
                        c_swl = 1'b1;
                        c_c   = c_c - ((c_swr && shb_pkg::abs8(c_c - 8'sd2) <= u_s)
                                       ? 8'sd2 : 8'sd1);
                    end
                end
                c_swr = 1'b0;
                c_ref = in_la;
            end else if (la_x > ref_x + delta_x) begin
                if (c_dir != shb_pkg::DIR_RIGHT && c_dir != shb_pkg::DIR_L2R) begin
                    if (c_dir == shb_pkg::DIR_NEUTRAL) begin
                        c_dir = shb_pkg::DIR_RIGHT;
                        c_c   = u_s;
                    end else if (!c_swr) begin
                        c_dir = shb_pkg::DIR_L2R;
                        c_swr = 1'b1;
                        c_c   = c_c + ((c_swl && shb_pkg::abs8(c_c + 8'sd2) <= u_s)
                                       ? 8'sd2 : 8'sd1);
                    end
                end
                c_swl = 1'b0;
                c_ref = in_la;
            end
        end else begin
            if (!c_jl) begin
                if (c_dir == shb_pkg::DIR_L2R) begin
                    c_dir = shb_pkg::DIR_R2L;
                    c_c   = c_c - ((shb_pkg::abs8(c_c - 8'sd2) <= u_s) ? 8'sd2 : 8'sd1);
                end else if (c_dir == shb_pkg::DIR_R2L) begin
                    c_dir = shb_pkg::DIR_L2R;
                    c_c   = c_c + ((shb_pkg::abs8(c_c + 8'sd2) <= u_s) ? 8'sd2 : 8'sd1);
                end
            end
            c_jl = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_cnt = r_cnt;
        n_dir = r_dir;       n_tc = r_tc;         n_swl = r_swl;
        n_swr = r_swr;       n_jl = r_jl;         n_ref = r_ref;
        n_ts = r_ts;         n_sa = r_sa;         n_p = r_p;
        n_ma = r_ma;         n_mb = r_mb;         n_mp = r_mp;
        n_dq = r_dq;         n_dd = r_dd;         n_rem = r_rem;
        n_sel = r_sel;       n_motor = r_motor;   n_agneg = r_agneg;
        n_ag = r_ag;         n_kag = r_kag;       n_num = r_num;
        n_numneg = r_numneg; n_cl = r_cl;         n_cr = r_cr;
        n_b = r_b;           n_wl = r_wl;         n_wr = r_wr;
        n_wneg_l = r_wneg_l; n_wneg_r = r_wneg_r; n_acc = r_acc;
        n_omot = r_omot;     n_ostr = r_ostr;
        n_ovalid = r_ovalid && !i_m_tready;

        m_sum = {1'b0, r_mp[63:32]} + {1'b0, (r_mb[0] ? r_ma : 32'd0)};
        d_t   = {r_rem, r_dq[31]};
        d_ge  = (d_t >= {1'b0, r_dd});
        d_sub = d_t - {1'b0, r_dd};

        mot_num = (r_ts[15] ? -$signed({1'b0, r_mp[26:0]}) : $signed({1'b0, r_mp[26:0]}))
                  + shb_pkg::MOTOR_OFFS;
        mot_q   = (mot_num + (mot_num[27] ? 28'sd8191 : 28'sd0)) >>> shb_pkg::SPEED_SHIFT;
        g       = $signed({4'b0000, d_eff}) + $signed({6'b000000, r_p}) - shb_pkg::GAIN_BASE;
        g_mag   = g[15] ? 16'(-g) : 16'(g);
        sa_mag  = r_sa[15] ? 16'(-r_sa) : 16'(r_sa);

        t2        = $signed({22'd0, r_mp[34:0]}) <<< shb_pkg::ANGLE_FRAC_BITS;
        offneg    = r_sel ? shb_pkg::OFFS_RIGHT_NEG : shb_pkg::OFFS_LEFT_NEG;
        num_mag   = r_num[56] ? 57'(-r_num) : 57'(r_num);
        num_shift = num_mag >> shb_pkg::CURVE_SHIFT;

        qs     = r_numneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        cmin_x = $signed({{22{r_cmin[10]}}, r_cmin});
        cmax_x = $signed({{22{r_cmax[10]}}, r_cmax});
        if (qs < cmin_x) begin
            cval = r_cmin;
        end else if (qs > cmax_x) begin
            cval = r_cmax;
        end else begin
            cval = qs[10:0];
        end

        bneg = r_sel ? (r_wneg_r ^ r_cr[10]) : (r_wneg_l ^ r_cl[10]);
        term = bneg ? -$signed({1'b0, r_mp[31:0]}) : $signed({1'b0, r_mp[31:0]});
        bq   = (r_acc + (r_acc[32] ? 33'sd32767 : 33'sd0)) >>> shb_pkg::BLEND_SHIFT;

        unique case (r_state)
            shb_pkg::ST_IDLE: begin
                if (s_acc && !in_drop) begin
                    n_ts    = in_ts;
                    n_sa    = in_sa;
                    n_p     = i_s_tdata[57:48];
                    n_dir   = c_dir;
                    n_tc    = c_c[5:0];
                    n_swl   = c_swl;
                    n_swr   = c_swr;
                    n_jl    = c_jl;
                    n_ref   = c_ref;
                    n_ma    = shb_pkg::MOTOR_GAIN;
                    n_mb    = {16'd0, (in_ts[15] ? 16'(-in_ts) : 16'(in_ts))};
                    n_mp    = 64'd0;
                    n_cnt   = 5'd0;
                    n_sel   = 1'b0;
                    n_ret   = shb_pkg::ST_F_MOT;
                    n_state = shb_pkg::ST_MRUN;
                end
            end
            shb_pkg::ST_MRUN: begin
                n_mp  = {m_sum, r_mp[31:1]};
                n_mb  = {1'b0, r_mb[31:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = r_ret;
                end
            end
            shb_pkg::ST_DRUN: begin
                n_rem = d_ge ? d_sub[11:0] : d_t[11:0];
                n_dq  = {r_dq[30:0], d_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = r_ret;
                end
            end
            shb_pkg::ST_F_MOT: begin
                if (mot_q < $signed({18'd0, r_mmin})) begin
                    n_motor = r_mmin;
                end else if (mot_q > $signed({18'd0, r_mmax})) begin
                    n_motor = r_mmax;
                end else begin
                    n_motor = mot_q[9:0];
                end
                n_agneg = r_sa[15] ^ g[15];
                n_ma    = {16'd0, g_mag};
                n_mb    = {16'd0, sa_mag};
                n_mp    = 64'd0;
                n_cnt   = 5'd0;
                n_ret   = shb_pkg::ST_F_AG;
                n_state = shb_pkg::ST_MRUN;
            end
            shb_pkg::ST_F_AG: begin
                n_ag    = r_mp[31:0];
                n_ma    = shb_pkg::COEF_LEFT;
                n_mb    = r_mp[31:0];
                n_mp    = 64'd0;
                n_cnt   = 5'd0;
                n_ret   = shb_pkg::ST_F_K;
                n_state = shb_pkg::ST_MRUN;
            end
            shb_pkg::ST_F_K: begin
                n_kag   = r_agneg ? -$signed({1'b0, r_mp[55:0]}) : $signed({1'b0, r_mp[55:0]});
                n_ma    = r_sel ? shb_pkg::OFFS_RIGHT_MAG : shb_pkg::OFFS_LEFT_MAG;
                n_mb    = {20'd0, d_eff};
                n_mp    = 64'd0;
                n_cnt   = 5'd0;
                n_ret   = shb_pkg::ST_F_O;
                n_state = shb_pkg::ST_MRUN;
            end
            shb_pkg::ST_F_O: begin
                n_num   = offneg ? (r_kag - t2) : (r_kag + t2);
                n_state = shb_pkg::ST_F_N;
            end
            shb_pkg::ST_F_N: begin
                n_numneg = r_num[56];
                n_dq     = num_shift[31:0];
                n_dd     = d_eff;
                n_rem    = 12'd0;
                n_cnt    = 5'd0;
                n_ret    = shb_pkg::ST_F_Q;
                n_state  = shb_pkg::ST_DRUN;
            end
            shb_pkg::ST_F_Q: begin
                if (!r_sel) begin
                    n_cl    = cval;
                    n_sel   = 1'b1;
                    n_ma    = shb_pkg::COEF_RIGHT;
                    n_mb    = r_ag;
                    n_mp    = 64'd0;
                    n_cnt   = 5'd0;
                    n_ret   = shb_pkg::ST_F_K;
                    n_state = shb_pkg::ST_MRUN;
                end else begin
                    n_cr  = cval;
                    n_sel = 1'b0;
                    if (r_dir == shb_pkg::DIR_LEFT) begin
                        n_b     = r_cl;
                        n_state = shb_pkg::ST_PUT;
                    end else if (r_dir == shb_pkg::DIR_RIGHT) begin
                        n_b     = cval;
                        n_state = shb_pkg::ST_PUT;
                    end else begin
                        n_wneg_l = wl_num[7];
                        n_dq     = {10'd0, wl_mag, 14'd0};
                        n_dd     = {8'd0, s_eff};
                        n_rem    = 12'd0;
                        n_cnt    = 5'd0;
                        n_ret    = shb_pkg::ST_F_W;
                        n_state  = shb_pkg::ST_DRUN;
                    end
                end
            end
            shb_pkg::ST_F_W: begin
                if (!r_sel) begin
                    n_wl     = r_dq[19:0];
                    n_sel    = 1'b1;
                    n_wneg_r = wr_num[7];
                    n_dq     = {10'd0, wr_mag, 14'd0};
                    n_rem    = 12'd0;
                    n_cnt    = 5'd0;
                    n_ret    = shb_pkg::ST_F_W;
                    n_state  = shb_pkg::ST_DRUN;
                end else begin
                    n_wr    = r_dq[19:0];
                    n_sel   = 1'b0;
                    n_ma    = {12'd0, r_wl};
                    n_mb    = {21'd0, cl_mag};
                    n_mp    = 64'd0;
                    n_cnt   = 5'd0;
                    n_ret   = shb_pkg::ST_F_B;
                    n_state = shb_pkg::ST_MRUN;
                end
            end
            shb_pkg::ST_F_B: begin
                if (!r_sel) begin
                    n_acc   = term;
                    n_sel   = 1'b1;
                    n_ma    = {12'd0, r_wr};
                    n_mb    = {21'd0, cr_mag};
                    n_mp    = 64'd0;
                    n_cnt   = 5'd0;
                    n_ret   = shb_pkg::ST_F_B;
                    n_state = shb_pkg::ST_MRUN;
                end else begin
                    n_acc   = r_acc + term;
                    n_sel   = 1'b0;
                    n_state = shb_pkg::ST_F_FIN;
                end
            end
            shb_pkg::ST_F_FIN: begin
                if (bq < -33'sd1024) begin
                    n_b = -11'sd1024;
                end else if (bq > 33'sd1023) begin
                    n_b = 11'sd1023;
                end else begin
                    n_b = bq[10:0];
                end
                n_state = shb_pkg::ST_PUT;
            end
            shb_pkg::ST_PUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_omot   = r_motor;
                    n_ostr   = r_b;
                    n_state  = shb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= shb_pkg::ST_IDLE;
            r_ret    <= shb_pkg::ST_IDLE;
            r_cnt    <= 5'd0;
            r_sel    <= 1'b0;
            r_ovalid <= 1'b0;
            r_dir    <= shb_pkg::DIR_NEUTRAL;
            r_tc     <= 6'sd0;
            r_swl    <= 1'b0;
            r_swr    <= 1'b0;
            r_jl     <= 1'b0;
            r_ref    <= 16'sd0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
            r_dir    <= n_dir;
            r_tc     <= n_tc;
            r_swl    <= n_swl;
            r_swr    <= n_swr;
            r_jl     <= n_jl;
            r_ref    <= n_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mmin   <= 10'd300;
            r_mmax   <= 10'd1000;
            r_cmin   <= -11'sd175;
            r_cmax   <= 11'sd225;
            r_hdelta <= 12'd41;
            r_tsteps <= 4'd4;
            r_gdiv   <= 12'd800;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                shb_pkg::CFG_MOTOR_MIN:   r_mmin   <= i_cfg_data[9:0];
                shb_pkg::CFG_MOTOR_MAX:   r_mmax   <= i_cfg_data[9:0];
                shb_pkg::CFG_STEER_MIN:   r_cmin   <= i_cfg_data[10:0];
                shb_pkg::CFG_STEER_MAX:   r_cmax   <= i_cfg_data[10:0];
                shb_pkg::CFG_HYST_DELTA:  r_hdelta <= i_cfg_data;
                shb_pkg::CFG_TRANS_STEPS: r_tsteps <= i_cfg_data[3:0];
                shb_pkg::CFG_GAIN_DIV:    r_gdiv   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts     <= n_ts;
        r_sa     <= n_sa;
        r_p      <= n_p;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_mp     <= n_mp;
        r_dq     <= n_dq;
        r_dd     <= n_dd;
        r_rem    <= n_rem;
        r_motor  <= n_motor;
        r_agneg  <= n_agneg;
        r_ag     <= n_ag;
        r_kag    <= n_kag;
        r_num    <= n_num;
        r_numneg <= n_numneg;
        r_cl     <= n_cl;
        r_cr     <= n_cr;
        r_b      <= n_b;
        r_wl     <= n_wl;
        r_wr     <= n_wr;
        r_wneg_l <= n_wneg_l;
        r_wneg_r <= n_wneg_r;
        r_acc    <= n_acc;
        r_omot   <= n_omot;
        r_ostr   <= n_ostr;
    end

endmodule

@@ rtl/shb_checker.sv @@
module shb_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [63:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [11:0] i_cfg_data
);

    logic s_acc, s_live;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign s_live = i_s_tuser[1] && (i_s_tdata[31:0] != 32'd0);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    a_busy_after_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_live |=> !o_s_tready)
        else $error("block idle after a live word");

    a_drop_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !s_live |=> o_s_tready)
        else $error("dropped word made the block busy");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result word appeared one cycle after input");

endmodule

bind steering_hysteresis_blend shb_assert u_shb_assert (.*);
